// ===== rtl/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types and constants for the scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STATE_GAIN        = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OBSERVATION_GAIN  = 2'd3;

    // register and field widths
    localparam int NOISE_W = 31;
    localparam int GAIN_W  = 32;
    localparam int MEAS_W  = 32;
    localparam int EST_W   = 32;
    localparam int COV_W   = 31;
    localparam int OUT_DATA_W = 64;

    localparam logic [NOISE_W-1:0] PROCESS_NOISE_RESET     = 31'd66;
    localparam logic [NOISE_W-1:0] MEASUREMENT_NOISE_RESET = 31'd3277;
    localparam logic [GAIN_W-1:0]  GAIN_RESET              = 32'd65536;

    // multiplier operand slice consumed per cycle
    localparam int CHUNK_W = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_OBS,
        ST_GAIN,
        ST_CORR,
        ST_COV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ===== rtl/skf_mul.sv =====
// ----------------------------------------------------------------------------
// skf_mul
// Shared fixed-point multiplier: sign-magnitude, one operand slice per cycle,
// then shift by the fraction bits, round toward minus infinity and saturate.
// ----------------------------------------------------------------------------
module skf_mul #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int VAL_WIDTH  = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [VAL_WIDTH-1:0] op_a,
    input  logic signed [VAL_WIDTH-1:0] op_b,
    output logic signed [VAL_WIDTH-1:0] product,
    output skf_pkg::unit_stat_t         stat
);
    import skf_pkg::*;

    localparam int NCH   = (VAL_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int BW    = NCH * CHUNK_W;
    localparam int AW    = VAL_WIDTH + BW;
    localparam int CNT_W = (NCH > 1) ? $clog2(NCH) : 1;

    localparam logic [AW-1:0] LIM_POS = AW'({(DATA_WIDTH-1){1'b1}});
    localparam logic [AW-1:0] LIM_NEG = LIM_POS + AW'(1);

    logic [VAL_WIDTH-1:0]         ma_reg;
    logic [BW-1:0]                mb_reg;
    logic                         neg_reg;
    logic [AW-1:0]                acc_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         busy_reg;
    logic                         fin_reg;
    logic                         done_reg;
    logic signed [VAL_WIDTH-1:0]  product_reg;

    logic [VAL_WIDTH-1:0]         ma_in;
    logic [VAL_WIDTH-1:0]         mb_in;
    logic [CHUNK_W-1:0]           chunk;
    logic [VAL_WIDTH+CHUNK_W-1:0] partial;
    logic [AW-1:0]                acc_next;
    logic [AW-1:0]                shifted;
    logic                         round_up;
    logic [AW-1:0]                qv;
    logic [AW-1:0]                lim;
    logic [AW-1:0]                qs;
    logic [VAL_WIDTH-1:0]         mag;
    logic signed [VAL_WIDTH-1:0]  product_next;

    assign ma_in = op_a[VAL_WIDTH-1] ? (~$unsigned(op_a) + 1'b1) : $unsigned(op_a);
    assign mb_in = op_b[VAL_WIDTH-1] ? (~$unsigned(op_b) + 1'b1) : $unsigned(op_b);

    // top slice first, accumulator shifts up one slice per step
    assign chunk    = mb_reg[BW-1 -: CHUNK_W];
    assign partial  = {{CHUNK_W{1'b0}}, ma_reg} * {{VAL_WIDTH{1'b0}}, chunk};
    assign acc_next = (acc_reg << CHUNK_W) + AW'(partial);

    assign shifted  = acc_reg >> FRAC_BITS;
    assign round_up = neg_reg && (acc_reg[FRAC_BITS-1:0] != '0);
    assign qv       = shifted + AW'(round_up);
    assign lim      = neg_reg ? LIM_NEG : LIM_POS;
    assign qs       = (qv > lim) ? lim : qv;
    assign mag      = qs[VAL_WIDTH-1:0];
    assign product_next = $signed(neg_reg ? (~mag + 1'b1) : mag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NCH - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= ma_in;
            mb_reg  <= BW'(mb_in);
            neg_reg <= op_a[VAL_WIDTH-1] ^ op_b[VAL_WIDTH-1];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            mb_reg  <= mb_reg << CHUNK_W;
        end
        if (fin_reg)
        begin
            product_reg <= product_next;
        end
    end

    assign product   = product_reg;
    assign stat.busy = busy_reg | fin_reg;
    assign stat.done = done_reg;

endmodule

// ===== rtl/skf_div.sv =====
// ----------------------------------------------------------------------------
// skf_div
// Restoring divider for the Kalman gain: one quotient bit per cycle, giving
// a fraction from 0 to 1.0 with the fraction bits truncated.
// ----------------------------------------------------------------------------
module skf_div #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [DATA_WIDTH-1:0]  num,
    input  logic [DATA_WIDTH:0]    den,
    output logic [FRAC_BITS:0]     quot,
    output skf_pkg::unit_stat_t    stat
);
    import skf_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS);
    localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

    logic [DATA_WIDTH+1:0] r_reg;
    logic [DATA_WIDTH:0]   d_reg;
    logic [FRAC_BITS-1:0]  q_reg;
    logic                  zero_reg;
    logic                  one_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [FRAC_BITS:0]    quot_reg;

    logic [DATA_WIDTH+1:0] rs;
    logic                  ge;
    logic [DATA_WIDTH+1:0] r_next;
    logic [FRAC_BITS-1:0]  q_next;

    assign rs     = {r_reg[DATA_WIDTH:0], 1'b0};
    assign ge     = rs >= {1'b0, d_reg};
    assign r_next = ge ? (rs - {1'b0, d_reg}) : rs;
    assign q_next = {q_reg[FRAC_BITS-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(FRAC_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg    <= {2'b00, num};
            d_reg    <= den;
            q_reg    <= '0;
            zero_reg <= (den == '0);
            one_reg  <= ({1'b0, num} >= den);
        end
        else if (busy_reg)
        begin
            r_reg <= r_next;
            q_reg <= q_next;
            if (cnt_reg == CNT_W'(FRAC_BITS - 1))
            begin
                // zero divisor keeps the prediction, numerator at or above it saturates
                if (zero_reg)
                    quot_reg <= '0;
                else if (one_reg)
                    quot_reg <= ONE_Q;
                else
                    quot_reg <= {1'b0, q_next};
            end
        end
    end

    assign quot      = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== rtl/scalar_kalman_filter.sv =====
// Flow: a measurement is accepted only in the idle state, once the previous result
// word has been loaded for output; the pace is set by the restoring divider and the
// four passes through the shared slice multiplier.
// Reset: estimate clears to 0, covariance to 1.0, registers to their defaults.
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// One-dimensional Kalman filter on a stream of fixed-point measurements.
// ----------------------------------------------------------------------------
module scalar_kalman_filter #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [skf_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [skf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [skf_pkg::MEAS_W-1:0]          s_tdata,  // [31:0] measurement
    // output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [skf_pkg::OUT_DATA_W-1:0]      m_tdata   // [31:0] estimate, [62:32] covariance
);
    import skf_pkg::*;

    localparam int VW = (DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 2;
    localparam int XW = (VW + 2 > 34) ? VW + 2 : 34;

    localparam logic signed [XW-1:0] SMAX =
        {{(XW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [XW-1:0] SMIN = ~SMAX;
    localparam logic [FRAC_BITS:0]   ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [VW-1:0] ONE_V = {{(VW-FRAC_BITS-1){1'b0}}, ONE_Q};

    function automatic logic signed [VW-1:0] sat_v(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] c;
        if (v > SMAX)
            c = SMAX;
        else if (v < SMIN)
            c = SMIN;
        else
            c = v;
        return $signed(c[VW-1:0]);
    endfunction

    function automatic logic signed [XW-1:0] ext_v(input logic signed [VW-1:0] v);
        return {{(XW-VW){v[VW-1]}}, v};
    endfunction

    // configuration registers
    logic [NOISE_W-1:0] q_cfg_reg;
    logic [NOISE_W-1:0] r_cfg_reg;
    logic [GAIN_W-1:0]  a_cfg_reg;
    logic [GAIN_W-1:0]  h_cfg_reg;

    // filter state and working registers
    state_t                 state_reg;
    state_t                 state_next;
    logic signed [VW-1:0]   x_reg;
    logic signed [VW-1:0]   p_reg;
    logic signed [VW-1:0]   z_reg;
    logic signed [VW-1:0]   mp_reg;
    logic signed [VW-1:0]   mx_reg;
    logic signed [VW-1:0]   t_reg;
    logic [FRAC_BITS:0]     k_reg;
    logic                   out_valid_reg;
    logic [EST_W-1:0]       est_reg;
    logic [COV_W-1:0]       cov_reg;

    logic signed [VW-1:0]   q_v;
    logic signed [VW-1:0]   r_v;
    logic signed [VW-1:0]   a_v;
    logic signed [VW-1:0]   h_v;
    logic signed [VW-1:0]   z_v;
    logic signed [XW-1:0]   x_ext;
    logic signed [XW-1:0]   p_ext;
    logic                   accept;
    logic                   out_load;

    logic                   mul_start;
    logic signed [VW-1:0]   mul_a;
    logic signed [VW-1:0]   mul_b;
    logic signed [VW-1:0]   mul_product;
    unit_stat_t             mul_stat;
    logic                   div_start;
    logic [DATA_WIDTH:0]    div_den;
    logic [FRAC_BITS:0]     div_quot;
    unit_stat_t             div_stat;

    assign q_v = sat_v({{(XW-NOISE_W){1'b0}}, q_cfg_reg});
    assign r_v = sat_v({{(XW-NOISE_W){1'b0}}, r_cfg_reg});
    assign a_v = sat_v({{(XW-GAIN_W){a_cfg_reg[GAIN_W-1]}}, a_cfg_reg});
    assign h_v = sat_v({{(XW-GAIN_W){h_cfg_reg[GAIN_W-1]}}, h_cfg_reg});
    assign z_v = sat_v({{(XW-MEAS_W){s_tdata[MEAS_W-1]}}, s_tdata});

    assign x_ext   = ext_v(x_reg);
    assign p_ext   = ext_v(p_reg);
    assign div_den = {1'b0, mp_reg[DATA_WIDTH-1:0]} + {1'b0, r_v[DATA_WIDTH-1:0]};

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    skf_mul #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .VAL_WIDTH  (VW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_product),
        .stat    (mul_stat)
    );

    skf_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mp_reg[DATA_WIDTH-1:0]),
        .den   (div_den),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = a_v;
        mul_b      = x_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_PRED;
                end
            end
            ST_PRED:
            begin
                mul_a = h_v;
                mul_b = mul_product;
                if (mul_stat.done)
                begin
                    mul_start  = 1'b1;
                    div_start  = 1'b1;
                    state_next = ST_OBS;
                end
            end
            ST_OBS:
            begin
                if (mul_stat.done)
                    state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                mul_a = {{(VW-FRAC_BITS-1){1'b0}}, div_quot};
                mul_b = t_reg;
                if (!div_stat.busy)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_CORR;
                end
            end
            ST_CORR:
            begin
                mul_a = ONE_V - {{(VW-FRAC_BITS-1){1'b0}}, k_reg};
                mul_b = mp_reg;
                if (mul_stat.done)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_COV;
                end
            end
            ST_COV:
            begin
                if (mul_stat.done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the output slot frees up
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            x_reg         <= '0;
            p_reg         <= ONE_V;
            q_cfg_reg     <= PROCESS_NOISE_RESET;
            r_cfg_reg     <= MEASUREMENT_NOISE_RESET;
            a_cfg_reg     <= GAIN_RESET;
            h_cfg_reg     <= GAIN_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_addr)
                    REG_PROCESS_NOISE:     q_cfg_reg <= cfg_wdata[NOISE_W-1:0];
                    REG_MEASUREMENT_NOISE: r_cfg_reg <= cfg_wdata[NOISE_W-1:0];
                    REG_STATE_GAIN:        a_cfg_reg <= cfg_wdata[GAIN_W-1:0];
                    REG_OBSERVATION_GAIN:  h_cfg_reg <= cfg_wdata[GAIN_W-1:0];
                    default:               ;
                endcase
            end
            if ((state_reg == ST_CORR) && mul_stat.done)
                x_reg <= sat_v(ext_v(mx_reg) + ext_v(mul_product));
            if ((state_reg == ST_COV) && mul_stat.done)
                p_reg <= mul_product;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            z_reg  <= z_v;
            mp_reg <= sat_v(p_ext + ext_v(q_v));
        end
        if ((state_reg == ST_PRED) && mul_stat.done)
            mx_reg <= mul_product;
        if ((state_reg == ST_OBS) && mul_stat.done)
            t_reg <= sat_v(ext_v(z_reg) - ext_v(mul_product));
        if ((state_reg == ST_GAIN) && !div_stat.busy)
            k_reg <= div_quot;
        if (out_load)
        begin
            est_reg <= x_ext[EST_W-1:0];
            cov_reg <= p_ext[COV_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, cov_reg, est_reg};

`ifndef SYNTHESIS
    a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_stat.busy)
        else $error("multiplier restarted while busy");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_ready_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!mul_stat.busy && !div_stat.busy))
        else $error("input ready while an arithmetic unit is busy");

    a_div_done_in_gain: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_GAIN))
        else $error("gain finished outside the gain wait");

    a_cov_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        !p_reg[VW-1])
        else $error("covariance went negative");
`endif

endmodule

// ===== sim/scalar_kalman_filter_tb.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_filter_tb
// Drives measurement words through the one-dimensional Kalman filter under
// several noise and gain settings and checks every estimate/covariance word
// against a fixed-point filter model kept inside the bench.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import skf_pkg::*;

    localparam int     FRAC         = 16;
    localparam longint UNITY        = 64'sd1 <<< FRAC;
    localparam longint WORD_MAX     = 64'sd2147483647;
    localparam longint WORD_MIN     = -WORD_MAX - 64'sd1;
    localparam int     RANDOM_ITEMS = 1280;

    typedef struct packed {
        logic [COV_W-1:0] covariance;
        logic [EST_W-1:0] estimate;
    } kf_result_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [MEAS_W-1:0]      s_tdata   = '0;   // [31:0] measurement
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;          // [31:0] estimate, [62:32] covariance

    // filter model state and register mirror
    longint cfg_q     = longint'(PROCESS_NOISE_RESET);
    longint cfg_r     = longint'(MEASUREMENT_NOISE_RESET);
    longint cfg_a     = longint'($signed(GAIN_RESET));
    longint cfg_h     = longint'($signed(GAIN_RESET));
    longint est_state = 0;
    longint cov_state = UNITY;

    kf_result_t pending_results [$];
    int         fail_count  = 0;
    int         burst_left  = 0;
    int         stall_mode  = 0;
    int         stall_span  = 0;
    longint     track_level = 0;

    scalar_kalman_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("scalar_kalman_filter_tb failed");
        $finish;
    end

    function automatic longint clamp_word(longint v);
        if (v > WORD_MAX)
            return WORD_MAX;
        if (v < WORD_MIN)
            return WORD_MIN;
        return v;
    endfunction

    // full product, floor shift, saturate
    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b;
        return clamp_word(p >>> FRAC);
    endfunction

    function automatic longint gain_frac(longint num, longint den);
        if (den == 0)
            return 0;
        if (num >= den)
            return UNITY;
        return (num <<< FRAC) / den;
    endfunction

    function automatic kf_result_t kalman_update(logic [MEAS_W-1:0] meas);
        longint     z;
        longint     mid_x;
        longint     mid_p;
        longint     k;
        longint     innov;
        kf_result_t res;
        z         = longint'($signed(meas));
        mid_x     = qmul(cfg_a, est_state);
        mid_p     = clamp_word(cov_state + cfg_q);
        k         = gain_frac(mid_p, mid_p + cfg_r);
        innov     = clamp_word(z - qmul(cfg_h, mid_x));
        est_state = clamp_word(mid_x + qmul(k, innov));
        cov_state = qmul(UNITY - k, mid_p);
        res.estimate   = est_state[EST_W-1:0];
        res.covariance = cov_state[COV_W-1:0];
        return res;
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_PROCESS_NOISE:     cfg_q = longint'(value[NOISE_W-1:0]);
            REG_MEASUREMENT_NOISE: cfg_r = longint'(value[NOISE_W-1:0]);
            REG_STATE_GAIN:        cfg_a = longint'($signed(value));
            REG_OBSERVATION_GAIN:  cfg_h = longint'($signed(value));
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // present one measurement word, return at the edge that accepts it
    task automatic send_measurement(input logic [MEAS_W-1:0] z);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= z;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(kalman_update(z));
    endtask

    // drop valid and wait for the filter to drain before touching registers
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_noise(bit allow_zero);
        case ($urandom_range(0, 7))
            0:       return allow_zero ? 32'd0 : 32'd1;
            1, 2:    return $urandom_range(1, 1000);
            3, 4:    return $urandom_range(1000, 200000);
            5:       return $urandom_range(200000, 32'h7FFF_FFFF);
            6:       return $urandom();
            default: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        int jitter;
        jitter = int'($urandom_range(0, 32768)) - 16384;
        case ($urandom_range(0, 9))
            0, 1, 2: return 32'h0001_0000;
            3, 4, 5: return 32'(65536 + jitter);
            6:       return 32'(-65536 + jitter);
            7:       return $urandom();
            8:       return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic test_defaults();
        logic [MEAS_W-1:0] zs [8] = '{32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                      32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'h0001_0000};
        foreach (zs[i])
            send_measurement(zs[i]);
        settle();
    endtask

    // R = 0 forces full gain; with Q = 0 the covariance then hits zero and
    // the next divisor is zero, so the prediction must stand
    task automatic test_zero_noise();
        write_reg(REG_PROCESS_NOISE, 32'd0);
        write_reg(REG_MEASUREMENT_NOISE, 32'd0);
        send_measurement(32'h0001_0000);
        send_measurement(32'h0002_0000);
        send_measurement(32'hFFFD_0000);
        settle();
        write_reg(REG_PROCESS_NOISE, 32'h0001_0000);
        send_measurement(32'h0005_0000);
        settle();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_PROCESS_NOISE, 32'hFFFF_FFFF);
        write_reg(REG_MEASUREMENT_NOISE, 32'h7FFF_FFFF);
        write_reg(REG_STATE_GAIN, 32'h7FFF_FFFF);
        write_reg(REG_OBSERVATION_GAIN, 32'h8000_0000);
        send_measurement(32'h7FFF_FFFF);
        send_measurement(32'h8000_0000);
        send_measurement(32'h1234_5678);
        send_measurement(32'd0);
        settle();
        write_reg(REG_PROCESS_NOISE, 32'd0);
        write_reg(REG_MEASUREMENT_NOISE, 32'd1);
        write_reg(REG_STATE_GAIN, 32'h8000_0000);
        write_reg(REG_OBSERVATION_GAIN, 32'h7FFF_FFFF);
        send_measurement(32'h8000_0000);
        send_measurement(32'h7FFF_FFFF);
        send_measurement(32'hDEAD_BEEF);
        settle();
        write_reg(REG_STATE_GAIN, 32'd0);
        write_reg(REG_OBSERVATION_GAIN, 32'd0);
        send_measurement(32'h0000_0064);
        send_measurement(32'hFFFF_FF9C);
        settle();
    endtask

    // phases of random settings; measurements mostly follow a drifting level
    task automatic test_random();
        int     sent;
        int     phase_items;
        int     spread;
        longint cand;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            write_reg(REG_PROCESS_NOISE, pick_noise(1'b1));
            write_reg(REG_MEASUREMENT_NOISE, pick_noise($urandom_range(0, 7) == 0));
            write_reg(REG_STATE_GAIN, pick_gain());
            write_reg(REG_OBSERVATION_GAIN, pick_gain());
            phase_items = $urandom_range(40, 160);
            if (phase_items > RANDOM_ITEMS - sent)
                phase_items = RANDOM_ITEMS - sent;
            repeat (phase_items)
            begin
                track_level = clamp_word(track_level + longint'($urandom_range(0, 8192)) - 4096);
                case ($urandom_range(0, 15))
                    12:      cand = longint'($signed($urandom()));
                    13:      case ($urandom_range(0, 3))
                                 0:       cand = WORD_MIN;
                                 1:       cand = WORD_MAX;
                                 2:       cand = 0;
                                 default: cand = -1;
                             endcase
                    14:
                    begin
                        track_level = longint'($signed($urandom()) >>> $urandom_range(0, 14));
                        cand = track_level;
                    end
                    default:
                    begin
                        spread = 1 << $urandom_range(4, 22);
                        cand = track_level + longint'($urandom_range(0, 2 * spread)) - spread;
                    end
                endcase
                cand = clamp_word(cand);
                send_measurement(cand[MEAS_W-1:0]);
            end
            sent += phase_items;
            settle();
        end
    endtask

    // receiver stall pattern, switching style every so often
    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(8, 120);
        end
        stall_span--;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 2) != 0);
            2:       m_tready <= ($urandom_range(0, 5) == 0);
            default: m_tready <= ((stall_span % 16) < 5);
        endcase
    end

    always @(posedge clk)
    begin : result_check
        kf_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with nothing pending, expected none, actual %h",
                         $time, m_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[EST_W-1:0] !== want.estimate)
                begin
                    $display("%0t: estimate mismatch, expected %h, actual %h",
                             $time, want.estimate, m_tdata[EST_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[EST_W +: COV_W] !== want.covariance)
                begin
                    $display("%0t: covariance mismatch, expected %h, actual %h",
                             $time, want.covariance, m_tdata[EST_W +: COV_W]);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_defaults();
        test_zero_noise();
        test_register_extremes();
        test_random();

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("scalar_kalman_filter_tb passed");
        else
            $display("scalar_kalman_filter_tb failed");
        $finish;
    end

endmodule
